@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Beat formats, the per-slot entry and the command broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;
    localparam int PAYLOAD_W     = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic signed [KEY_W-1:0]     key;
        logic        [PAYLOAD_W-1:0] payload;
    } in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0]       head_key;
        logic        [PAYLOAD_W-1:0]   head_payload;
        logic                          is_empty;
        logic        [COUNT_OUT_W-1:0] entry_count;
        logic                          push_dropped;
    } out_t;

    typedef struct packed {
        logic                        valid;
        logic signed [KEY_W-1:0]     key;
        logic        [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                        push;
        logic                        pop;
        logic signed [KEY_W-1:0]     key;
        logic        [PAYLOAD_W-1:0] payload;
    } cmd_t;

endpackage

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on a push it holds, takes the new entry or takes its left
// neighbor; on a pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  spq_pkg::cmd_t   cmd,
    input  spq_pkg::entry_t left,
    input  logic            left_ins,
    input  spq_pkg::entry_t right,
    output spq_pkg::entry_t entry,
    output logic            ins
);

    logic                                 valid_reg;
    logic signed [spq_pkg::KEY_W-1:0]     key_reg;
    logic        [spq_pkg::PAYLOAD_W-1:0] payload_reg;
    spq_pkg::entry_t                      entry_cur;
    spq_pkg::entry_t                      entry_next;
    logic                                 own_ins;

    assign entry_cur.valid   = valid_reg;
    assign entry_cur.key     = key_reg;
    assign entry_cur.payload = payload_reg;

    // head: insert only before a strictly larger key; others: before a key >= new
    always_comb
    begin
        if (!entry_cur.valid)
            own_ins = 1'b1;
        else if (IS_HEAD)
            own_ins = $signed(cmd.key) < $signed(entry_cur.key);
        else
            own_ins = !($signed(entry_cur.key) < $signed(cmd.key));
    end

    assign ins = own_ins | (left_ins & !IS_HEAD);

    always_comb
    begin
        entry_next = entry_cur;
        if (cmd.push)
        begin
            if (left_ins && !IS_HEAD)
                entry_next = left;
            else if (own_ins)
            begin
                entry_next.valid   = 1'b1;
                entry_next.key     = cmd.key;
                entry_next.payload = cmd.payload;
            end
        end
        else if (cmd.pop)
            entry_next = right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= entry_next.valid;
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= entry_next.key;
        payload_reg <= entry_next.payload;
    end

    assign entry = entry_cur;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue: minimum-first priority queue on a chain of cells
// Usage:
//   Input beat: item (kind, key, payload) is taken at a clock edge with
//   start high and busy low. busy stays low: a beat may follow every cycle.
//   Each beat yields one result beat on result, marked by done for exactly
//   one cycle, the cycle after the input beat (throughput one beat per
//   cycle). The receiver cannot stall; it must take each beat.
//   A push compares its key in every cell at once; each cell holds, takes
//   the new entry or takes its left neighbor, so the row stays sorted.
//   A pop shifts the row one cell toward the head.
//   A push to a full queue is dropped and flagged; a pop on an empty queue
//   changes nothing. The head fields read zero while the queue is empty.
//   Reset clears all valid bits and the count; no clearing pass is needed,
//   so the first beat may come right after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::in_t  item,
    output logic          done,
    output spq_pkg::out_t result
);

    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::cmd_t   cmd;
    spq_pkg::entry_t cells   [DEPTH];
    logic            ins_vec [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             done_reg;
    logic             accept;
    logic             full;
    logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_ext;

    assign busy   = 1'b0;
    assign accept = start & !busy;
    assign full   = (count_reg == CW'(DEPTH));

    assign cmd.push    = accept && (item.kind == spq_pkg::KIND_PUSH) && !full;
    assign cmd.pop     = accept && (item.kind == spq_pkg::KIND_POP) && (count_reg != '0);
    assign cmd.key     = item.key;
    assign cmd.payload = item.payload;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            spq_pkg::entry_t left_e;
            spq_pkg::entry_t right_e;
            logic            left_i;

            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign left_i = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cells[gi-1];
                assign left_i = ins_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cells[gi+1];
            end

            spq_cell #(
                .IS_HEAD (gi == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .left     (left_e),
                .left_ins (left_i),
                .right    (right_e),
                .entry    (cells[gi]),
                .ins      (ins_vec[gi])
            );

            assign valid_vec[gi] = cells[gi].valid;
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = 1'b0;
        if (cmd.push)
            count_next = count_reg + CW'(1);
        else if (cmd.pop)
            count_next = count_reg - CW'(1);
        if (accept && (item.kind == spq_pkg::KIND_PUSH) && full)
            dropped_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            done_reg    <= accept;
        end
    end

    assign count_ext = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    assign done                = done_reg;
    assign result.head_key     = cells[0].valid ? cells[0].key : '0;
    assign result.head_payload = cells[0].valid ? cells[0].payload : '0;
    assign result.is_empty     = !cells[0].valid;
    assign result.entry_count  = count_ext[spq_pkg::COUNT_OUT_W-1:0];
    assign result.push_dropped = dropped_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("count does not match valid cells");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (cells[0].valid && cells[1].valid) |-> !($signed(cells[1].key) < $signed(cells[0].key)))
        else $error("head is not the minimum");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result beat without input beat");

    a_drop_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_next |-> (full && !cmd.push))
        else $error("push dropped while not full");
`endif

endmodule

@@ test/sorted_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// Drives push and pop beats with random gaps and keeps a shadow copy of the
// sorted queue. Every result beat is matched against the shadow's head,
// empty flag, count and drop flag, or a typed table row's report. A short
// table covers the empty queue, the key extremes, equal keys and the full
// queue. Random phases with shifting push rates and key spreads follow.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

    localparam int QUEUE_DEPTH     = spq_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_BEATS    = 1400;
    localparam int WATCHDOG_CYCLES = 500;

    localparam logic signed [spq_pkg::KEY_W-1:0] KEY_MIN =
        {1'b1, {(spq_pkg::KEY_W-1){1'b0}}};
    localparam logic signed [spq_pkg::KEY_W-1:0] KEY_MAX =
        {1'b0, {(spq_pkg::KEY_W-1){1'b1}}};

    typedef struct packed {
        spq_pkg::in_t  beat;
        logic          typed;
        spq_pkg::out_t want;
    } stim_row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    spq_pkg::in_t  item;
    logic          done;
    spq_pkg::out_t result;

    logic          typed_valid;
    spq_pkg::out_t typed_want;

    logic signed [spq_pkg::KEY_W-1:0]     shadow_keys [QUEUE_DEPTH];
    logic        [spq_pkg::PAYLOAD_W-1:0] shadow_payloads [QUEUE_DEPTH];
    int                                   shadow_count = 0;

    spq_pkg::out_t pending_reports [$];
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    stim_row_t     stim_table [$];

    sorted_priority_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic spq_pkg::in_t mk_beat(input logic kind,
                                             input logic signed [spq_pkg::KEY_W-1:0] key,
                                             input logic [spq_pkg::PAYLOAD_W-1:0] payload);
        spq_pkg::in_t b;
        b.kind    = kind;
        b.key     = key;
        b.payload = payload;
        return b;
    endfunction

    function automatic spq_pkg::out_t mk_report(input logic signed [spq_pkg::KEY_W-1:0] key,
                                                input logic [spq_pkg::PAYLOAD_W-1:0] payload,
                                                input logic empty, input int count,
                                                input logic dropped);
        spq_pkg::out_t r;
        r.head_key     = key;
        r.head_payload = payload;
        r.is_empty     = empty;
        r.entry_count  = spq_pkg::COUNT_OUT_W'(count);
        r.push_dropped = dropped;
        return r;
    endfunction

    // apply one beat to the shadow queue and return the head report after it
    function automatic spq_pkg::out_t advance_shadow(input spq_pkg::in_t b);
        spq_pkg::out_t r;
        int            pos;
        logic          dropped;
        r       = '0;
        dropped = 1'b0;
        if (b.kind == spq_pkg::KIND_PUSH)
        begin
            if (shadow_count >= QUEUE_DEPTH)
                dropped = 1'b1;
            else
            begin
                if (shadow_count == 0 || $signed(b.key) < shadow_keys[0])
                    pos = 0;
                else
                begin
                    pos = 1;
                    while (pos < shadow_count && shadow_keys[pos] < $signed(b.key))
                        pos++;
                end
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_keys[i]     = shadow_keys[i-1];
                    shadow_payloads[i] = shadow_payloads[i-1];
                end
                shadow_keys[pos]     = b.key;
                shadow_payloads[pos] = b.payload;
                shadow_count++;
            end
        end
        else if (shadow_count > 0)
        begin
            for (int i = 0; i + 1 < shadow_count; i++)
            begin
                shadow_keys[i]     = shadow_keys[i+1];
                shadow_payloads[i] = shadow_payloads[i+1];
            end
            shadow_count--;
        end
        if (shadow_count == 0)
            r.is_empty = 1'b1;
        else
        begin
            r.head_key     = shadow_keys[0];
            r.head_payload = shadow_payloads[0];
        end
        r.entry_count  = spq_pkg::COUNT_OUT_W'(shadow_count);
        r.push_dropped = dropped;
        return r;
    endfunction

    task automatic report_mismatch(input string field,
                                   input logic [spq_pkg::KEY_W-1:0] want,
                                   input logic [spq_pkg::KEY_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endtask

    // check result beats, then record the expectation of each accepted beat
    always @(posedge clk)
    begin
        spq_pkg::out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_reports.size() == 0)
                    report_mismatch("unexpected result", '0, result.head_key);
                else
                begin
                    want = pending_reports.pop_front();
                    if (result.head_key !== want.head_key)
                        report_mismatch("head_key", want.head_key, result.head_key);
                    if (result.head_payload !== want.head_payload)
                        report_mismatch("head_payload", want.head_payload,
                                        result.head_payload);
                    if (result.is_empty !== want.is_empty)
                        report_mismatch("is_empty", spq_pkg::KEY_W'(want.is_empty),
                                        spq_pkg::KEY_W'(result.is_empty));
                    if (result.entry_count !== want.entry_count)
                        report_mismatch("entry_count", spq_pkg::KEY_W'(want.entry_count),
                                        spq_pkg::KEY_W'(result.entry_count));
                    if (result.push_dropped !== want.push_dropped)
                        report_mismatch("push_dropped", spq_pkg::KEY_W'(want.push_dropped),
                                        spq_pkg::KEY_W'(result.push_dropped));
                end
            end
            if (start && !busy)
            begin
                want = advance_shadow(item);
                if (typed_valid)
                    want = typed_want;
                pending_reports.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("sorted_priority_queue test failed");
            $finish;
        end
    end

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input spq_pkg::in_t b, input logic typed,
                             input spq_pkg::out_t want, input int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        item        <= b;
        typed_valid <= typed;
        typed_want  <= want;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic signed [spq_pkg::KEY_W-1:0] draw_key(input int spread);
        logic signed [spq_pkg::KEY_W-1:0] k;
        case (spread)
            0: k = $urandom;
            1: k = $signed(spq_pkg::KEY_W'($urandom_range(0, 6))) - 3;
            default:
            begin
                case ($urandom_range(0, 6))
                    0: k = KEY_MIN;
                    1: k = KEY_MIN + 1;
                    2: k = -1;
                    3: k = 0;
                    4: k = 1;
                    5: k = KEY_MAX - 1;
                    default: k = KEY_MAX;
                endcase
            end
        endcase
        return k;
    endfunction

    initial
    begin
        int           sent;
        int           phase_len;
        int           push_pct;
        int           spread;
        logic         burst;
        spq_pkg::in_t b;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        typed_valid = 1'b0;
        typed_want  = '0;

        stim_table.push_back('{mk_beat(spq_pkg::KIND_POP, 0, 0), 1'b1,
                               mk_report(0, 0, 1'b1, 0, 1'b0)});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MAX, 32'hFFFF_FFFF), 1'b1,
                               mk_report(KEY_MAX, 32'hFFFF_FFFF, 1'b0, 1, 1'b0)});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MIN, 0), 1'b1,
                               mk_report(KEY_MIN, 0, 1'b0, 2, 1'b0)});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MIN, 1), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 0, 2), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MAX, 3), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, -1, 4), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 1, 5), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 0, 6), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MIN + 1, 7), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MAX - 1, 8), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 32'sh5555_5555, 9), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 32'shAAAA_AAAA, 10), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 100, 11), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, -100, 12), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 7, 13), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 42, 14), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MAX, 32'hFFFF_FFFF), 1'b1,
                               mk_report(KEY_MIN, 0, 1'b0, QUEUE_DEPTH, 1'b1)});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_POP, KEY_MAX, 32'hFFFF_FFFF), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, KEY_MIN, 15), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_PUSH, 0, 0), 1'b1,
                               mk_report(KEY_MIN, 1, 1'b0, QUEUE_DEPTH, 1'b1)});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_POP, 0, 0), 1'b0, '0});
        stim_table.push_back('{mk_beat(spq_pkg::KIND_POP, 0, 0), 1'b0, '0});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
            send_beat(stim_table[i].beat, stim_table[i].typed, stim_table[i].want,
                      $urandom_range(0, 15));

        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: push_pct = 20;
                1: push_pct = 50;
                default: push_pct = 80;
            endcase
            spread = $urandom_range(0, 2);
            burst  = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                b.kind    = ($urandom_range(0, 99) < push_pct) ? spq_pkg::KIND_PUSH
                                                               : spq_pkg::KIND_POP;
                b.key     = draw_key(spread);
                b.payload = $urandom;
                send_beat(b, 1'b0, '0, burst ? 0 : $urandom_range(0, 15));
                sent++;
            end
        end
        start       <= 1'b0;
        typed_valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("sorted_priority_queue test passed");
        else
            $display("sorted_priority_queue test failed");
        $finish;
    end

endmodule
